// File: design/pet_pkg.sv
// Shared definitions for the periodic event timer bank.
// Holds the bank size, action codes and the per-timer control struct.
// No dependencies.
package pet_pkg;

  localparam int unsigned TimerCount = 8;  // number of event timers, 1 to 32
  localparam int unsigned ActionW    = 3;
  localparam int unsigned TimerIdW   = 3;
  localparam int unsigned PeriodW    = 16;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned IdCmpW     = 8;  // wide enough to compare any id with any timer index

  typedef enum logic [ActionW-1:0] {
    ACT_TICK       = 3'd0,
    ACT_SET_PERIOD = 3'd1,
    ACT_READ_FLAG  = 3'd2,
    ACT_CLEAR_FLAG = 3'd3,
    ACT_READ_CLEAR = 3'd4,
    ACT_READ_TIME  = 3'd5
  } action_e;

  typedef struct packed {
    logic tick;
    logic load;
    logic clear;
  } timer_ctrl_t;

endpackage

// File: design/pet_timer.sv
// One periodic event timer: down counter, reload value and sticky flag.
// Depends on pet_pkg for widths and the control struct.
module pet_timer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pet_pkg::timer_ctrl_t       ctrl_i,
  input  logic [pet_pkg::PeriodW-1:0] period_i,
  output logic                       flag_o
);

  logic [pet_pkg::PeriodW-1:0] count_q, count_d;
  logic [pet_pkg::PeriodW-1:0] reload_q, reload_d;
  logic                        flag_q, flag_d;

  always_comb begin
    count_d  = count_q;
    reload_d = reload_q;
    flag_d   = flag_q;
    if (ctrl_i.tick) begin
      if (count_q != '0) begin
        count_d = count_q - pet_pkg::PeriodW'(1);
      end else begin
        // expired: reload and raise the sticky flag
        count_d = reload_q;
        flag_d  = 1'b1;
      end
    end else if (ctrl_i.load) begin
      count_d  = period_i;
      reload_d = period_i;
      flag_d   = 1'b0;
    end else if (ctrl_i.clear) begin
      flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      reload_q <= '0;
      flag_q   <= 1'b0;
    end else begin
      count_q  <= count_d;
      reload_q <= reload_d;
      flag_q   <= flag_d;
    end
  end

  assign flag_o = flag_q;

endmodule

// File: design/periodic_event_timer_bank_top.sv
// Top level of the periodic event timer bank.
// Depends on pet_pkg and instantiates one pet_timer per event timer.
//
// Usage: a request (action_i, timer_id_i, period_i) is taken at a rising edge
// where start_i is high and busy_o is low. busy_o never rises, so one request
// can be issued in every cycle. Requests are registered first; in the next
// cycle the timers and the tick counter update and any result is registered.
// Read flag, read and clear flag and read time each give one result, shown
// on flag_value_o and time_value_o for exactly one cycle with done_o high,
// once the request has passed the request register and then the result registers.
// Other actions give no result. Results leave in request order; the
// receiver cannot stall, so none is ever held back.
// Ids beyond the bank are ignored for writes and read back a zero flag.
// At reset all counts, reload values, flags and the tick counter clear,
// and no request or result is pending.
module periodic_event_timer_bank_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [pet_pkg::ActionW-1:0]   action_i,
  input  logic [pet_pkg::TimerIdW-1:0]  timer_id_i,
  input  logic [pet_pkg::PeriodW-1:0]   period_i,
  output logic                          done_o,
  output logic                          flag_value_o,
  output logic [pet_pkg::TimeW-1:0]     time_value_o
);

  localparam int unsigned N = pet_pkg::TimerCount;

  // request register
  logic                         req_vld_q;
  pet_pkg::action_e             act_q;
  logic [pet_pkg::TimerIdW-1:0] id_q;
  logic [pet_pkg::PeriodW-1:0]  period_q;

  logic [pet_pkg::TimeW-1:0]    tick_total_q, tick_total_d;
  logic                         done_q, done_d;
  logic                         flag_res_q, flag_res_d;
  logic [pet_pkg::TimeW-1:0]    time_res_q, time_res_d;

  logic [N-1:0]                 sel;
  logic [N-1:0]                 flags;
  logic                         is_tick, is_load, is_clear, is_read_flag, is_read_time;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      act_q    <= pet_pkg::action_e'(action_i);
      id_q     <= timer_id_i;
      period_q <= period_i;
    end
  end

  always_comb begin
    is_tick      = 1'b0;
    is_load      = 1'b0;
    is_clear     = 1'b0;
    is_read_flag = 1'b0;
    is_read_time = 1'b0;
    if (req_vld_q) begin
      case (act_q)
        pet_pkg::ACT_TICK:       is_tick = 1'b1;
        pet_pkg::ACT_SET_PERIOD: is_load = 1'b1;
        pet_pkg::ACT_READ_FLAG:  is_read_flag = 1'b1;
        pet_pkg::ACT_CLEAR_FLAG: is_clear = 1'b1;
        pet_pkg::ACT_READ_CLEAR: begin
          is_read_flag = 1'b1;
          is_clear     = 1'b1;
        end
        pet_pkg::ACT_READ_TIME:  is_read_time = 1'b1;
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_timer
    pet_pkg::timer_ctrl_t ctrl;

    // an id beyond the bank selects no timer
    assign sel[k] = (pet_pkg::IdCmpW'(id_q) == pet_pkg::IdCmpW'(k));
    assign ctrl.tick  = is_tick;
    assign ctrl.load  = is_load && sel[k];
    assign ctrl.clear = is_clear && sel[k];

    pet_timer u_timer (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .period_i (period_q),
      .flag_o   (flags[k])
    );
  end

  always_comb begin
    tick_total_d = tick_total_q;
    if (is_tick) begin
      tick_total_d = tick_total_q + pet_pkg::TimeW'(1);
    end
    done_d     = is_read_flag || is_read_time;
    // flag as it stood before this request
    flag_res_d = is_read_flag && (|(flags & sel));
    time_res_d = is_read_time ? tick_total_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_total_q <= '0;
      done_q       <= 1'b0;
    end else begin
      tick_total_q <= tick_total_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flag_res_q <= flag_res_d;
    time_res_q <= time_res_d;
  end

  assign done_o       = done_q;
  assign flag_value_o = flag_res_q;
  assign time_value_o = time_res_q;

  // a result carries either a flag or a time, never both
  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!flag_value_o || time_value_o == '0))
    else $error("result carries both a flag and a time");

  // every result stems from a registered request
  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req_vld_q))
    else $error("result without a request");

  // a tick advances the tick counter by one
  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_tick |=> tick_total_q == $past(tick_total_q) + pet_pkg::TimeW'(1))
    else $error("tick counter did not advance");

  // write-only actions never produce a result
  a_no_result_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (action_i == pet_pkg::ACT_TICK ||
      action_i == pet_pkg::ACT_SET_PERIOD || action_i == pet_pkg::ACT_CLEAR_FLAG))
    |-> ##2 !done_o)
    else $error("result for a write-only action");

endmodule

// File: test/periodic_event_timer_bank_top_test.sv
// Testbench for periodic_event_timer_bank_top: directed then random requests,
// with results checked against a cycle-free predictor of the timer bank.
// Depends on pet_pkg and the timer bank RTL.
`timescale 1ns / 100ps

module periodic_event_timer_bank_top_test;

  localparam logic [pet_pkg::ActionW-1:0] ActSpareLo = 3'd6;
  localparam logic [pet_pkg::ActionW-1:0] ActSpareHi = 3'd7;
  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned RandomCount  = 1250;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned SteadyFirst  = 500;  // requests issued back to back in this window
  localparam int unsigned SteadyLast   = 800;

  typedef struct packed {
    logic [pet_pkg::ActionW-1:0]  action;
    logic [pet_pkg::TimerIdW-1:0] timer_id;
    logic [pet_pkg::PeriodW-1:0]  period;
  } request_t;

  typedef struct packed {
    logic                      flag;
    logic [pet_pkg::TimeW-1:0] ticks;
  } read_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic [pet_pkg::ActionW-1:0]  action_i;
  logic [pet_pkg::TimerIdW-1:0] timer_id_i;
  logic [pet_pkg::PeriodW-1:0]  period_i;
  logic                         done_o;
  logic                         flag_value_o;
  logic [pet_pkg::TimeW-1:0]    time_value_o;

  request_t     request_queue[$];
  read_result_t expected_reads[$];

  // predicted state of the bank
  logic [pet_pkg::PeriodW-1:0] count_left[pet_pkg::TimerCount]   = '{default: '0};
  logic [pet_pkg::PeriodW-1:0] reload_value[pet_pkg::TimerCount] = '{default: '0};
  logic                        fired[pet_pkg::TimerCount]        = '{default: 1'b0};
  logic [pet_pkg::TimeW-1:0]   tick_total = '0;

  int unsigned fail_count   = 0;
  int unsigned issued_count = 0;
  int unsigned stall_cycles = 0;
  bit          req_taken    = 1'b0;

  periodic_event_timer_bank_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .action_i     (action_i),
    .timer_id_i   (timer_id_i),
    .period_i     (period_i),
    .done_o       (done_o),
    .flag_value_o (flag_value_o),
    .time_value_o (time_value_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [pet_pkg::TimeW-1:0] got,
                                 input logic [pet_pkg::TimeW-1:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic push_request(input logic [pet_pkg::ActionW-1:0] act,
                              input logic [pet_pkg::TimerIdW-1:0] id,
                              input logic [pet_pkg::PeriodW-1:0] per);
    request_t req;
    req.action   = act;
    req.timer_id = id;
    req.period   = per;
    request_queue.push_back(req);
  endtask

  // Apply one accepted request to the predicted bank and queue any read result.
  task automatic predict_request(input request_t req);
    read_result_t res;
    logic         hit;
    hit = 32'(req.timer_id) < pet_pkg::TimerCount;
    res = '0;
    case (req.action)
      pet_pkg::ACT_TICK: begin
        for (int k = 0; k < pet_pkg::TimerCount; k++) begin
          if (count_left[k] != '0) begin
            count_left[k] = count_left[k] - pet_pkg::PeriodW'(1);
          end else begin
            count_left[k] = reload_value[k];
            fired[k] = 1'b1;
          end
        end
        tick_total = tick_total + pet_pkg::TimeW'(1);
      end
      pet_pkg::ACT_SET_PERIOD: begin
        if (hit) begin
          count_left[req.timer_id]   = req.period;
          reload_value[req.timer_id] = req.period;
          fired[req.timer_id]        = 1'b0;
        end
      end
      pet_pkg::ACT_READ_FLAG: begin
        if (hit) res.flag = fired[req.timer_id];
        expected_reads.push_back(res);
      end
      pet_pkg::ACT_CLEAR_FLAG: begin
        if (hit) fired[req.timer_id] = 1'b0;
      end
      pet_pkg::ACT_READ_CLEAR: begin
        if (hit) begin
          res.flag = fired[req.timer_id];
          fired[req.timer_id] = 1'b0;
        end
        expected_reads.push_back(res);
      end
      pet_pkg::ACT_READ_TIME: begin
        res.ticks = tick_total;
        expected_reads.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Sample at the rising edge: take requests into the predictor, check results.
  always @(posedge clk_i) begin
    read_result_t want;
    req_taken = 1'b0;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        req_taken = 1'b1;
        predict_request('{action: action_i, timer_id: timer_id_i, period: period_i});
      end
      if (done_o) begin
        if (expected_reads.size() == 0) begin
          report_mismatch("unexpected result", time_value_o, '0);
        end else begin
          want = expected_reads.pop_front();
          if (flag_value_o !== want.flag) begin
            report_mismatch("flag_value", pet_pkg::TimeW'(flag_value_o),
                            pet_pkg::TimeW'(want.flag));
          end
          if (time_value_o !== want.ticks) begin
            report_mismatch("time_value", time_value_o, want.ticks);
          end
        end
      end
    end
  end

  // Drive at the falling edge; hold a request until it is taken.
  always @(negedge clk_i) begin
    request_t req;
    bit       gaps_on;
    if (rst_ni && (!start_i || req_taken)) begin
      gaps_on = !(issued_count >= SteadyFirst && issued_count < SteadyLast);
      if (request_queue.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 17)) begin
        req = request_queue.pop_front();
        start_i    <= 1'b1;
        action_i   <= req.action;
        timer_id_i <= req.timer_id;
        period_i   <= req.period;
        issued_count++;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !((start_i && !busy_o) || done_o)) stall_cycles++;
    else stall_cycles = 0;
    if (stall_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned useful;
    int unsigned pick;
    logic [pet_pkg::PeriodW-1:0] per;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    action_i     = pet_pkg::ACT_TICK;
    timer_id_i   = '0;
    period_i     = '0;

    // directed: reset values, fire on zero period, read and clear, extremes
    push_request(pet_pkg::ACT_READ_TIME, 3'd0, 16'hffff);
    push_request(pet_pkg::ACT_READ_FLAG, 3'd0, 16'h0000);
    push_request(pet_pkg::ACT_TICK, 3'd7, 16'hffff);
    push_request(pet_pkg::ACT_READ_FLAG, 3'd7, 16'h0000);
    push_request(pet_pkg::ACT_READ_CLEAR, 3'd7, 16'h0000);
    push_request(pet_pkg::ACT_READ_FLAG, 3'd7, 16'h0000);
    push_request(pet_pkg::ACT_CLEAR_FLAG, 3'd0, 16'h0000);
    push_request(pet_pkg::ACT_READ_FLAG, 3'd0, 16'h0000);
    push_request(pet_pkg::ACT_SET_PERIOD, 3'd3, 16'hffff);
    push_request(pet_pkg::ACT_READ_FLAG, 3'd3, 16'h0000);
    push_request(pet_pkg::ACT_SET_PERIOD, 3'd5, 16'd2);
    push_request(pet_pkg::ACT_TICK, 3'd0, 16'h0000);
    push_request(pet_pkg::ACT_TICK, 3'd0, 16'h0000);
    push_request(pet_pkg::ACT_READ_FLAG, 3'd5, 16'h0000);
    push_request(pet_pkg::ACT_TICK, 3'd0, 16'h0000);
    push_request(pet_pkg::ACT_READ_CLEAR, 3'd5, 16'h0000);
    push_request(ActSpareLo, 3'd1, 16'hffff);
    push_request(ActSpareHi, 3'd2, 16'h5a5a);
    push_request(pet_pkg::ACT_READ_TIME, 3'd7, 16'h0000);
    push_request(pet_pkg::ACT_CLEAR_FLAG, 3'd1, 16'h0000);
    push_request(pet_pkg::ACT_READ_CLEAR, 3'd1, 16'h0000);
    push_request(pet_pkg::ACT_SET_PERIOD, 3'd0, 16'h0000);
    push_request(pet_pkg::ACT_TICK, 3'd0, 16'h0000);
    push_request(pet_pkg::ACT_READ_CLEAR, 3'd0, 16'h0000);

    // random: mostly ticks and short periods so timers fire often
    useful = 0;
    while (useful < RandomCount) begin
      pick = $urandom_range(0, 99);
      per  = pet_pkg::PeriodW'($urandom);
      if (pick < 40) begin
        push_request(pet_pkg::ACT_TICK, pet_pkg::TimerIdW'($urandom), per);
      end else if (pick < 55) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: per = pet_pkg::PeriodW'($urandom_range(0, 6));
          6, 7, 8:          per = pet_pkg::PeriodW'($urandom_range(0, 40));
          default: ;
        endcase
        push_request(pet_pkg::ACT_SET_PERIOD, pet_pkg::TimerIdW'($urandom), per);
      end else if (pick < 70) begin
        push_request(pet_pkg::ACT_READ_FLAG, pet_pkg::TimerIdW'($urandom), per);
      end else if (pick < 78) begin
        push_request(pet_pkg::ACT_CLEAR_FLAG, pet_pkg::TimerIdW'($urandom), per);
      end else if (pick < 90) begin
        push_request(pet_pkg::ACT_READ_CLEAR, pet_pkg::TimerIdW'($urandom), per);
      end else if (pick < 97) begin
        push_request(pet_pkg::ACT_READ_TIME, pet_pkg::TimerIdW'($urandom), per);
      end else begin
        push_request($urandom_range(0, 1) ? ActSpareHi : ActSpareLo,
                     pet_pkg::TimerIdW'($urandom), per);
        useful--;  // ignored codes do not count
      end
      useful++;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() != 0 || start_i || expected_reads.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_reads.size() != 0) begin
      report_mismatch("results missing", pet_pkg::TimeW'(expected_reads.size()), '0);
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pet_pkg.sv
design/pet_timer.sv
design/periodic_event_timer_bank_top.sv
test/periodic_event_timer_bank_top_test.sv
